[hdl/cpf_pkg.sv]
// Package for the CRC-16 packet framer: byte type, framing constants and the
// reflected CRC-16 byte update. No dependencies.
package cpf_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] crc_t;

  localparam byte_t START_BYTE = 8'hC0;
  localparam byte_t END_BYTE   = 8'hC1;
  localparam crc_t  CRC_POLY   = 16'h8408;

  // Fold one byte into the CRC, least significant bit first.
  function automatic crc_t crc_fold(input crc_t crc_in, input byte_t data);
    crc_t  crc;
    byte_t d;
    logic  mix;
    crc = crc_in;
    d   = data;
    for (int k = 0; k < 8; k++) begin
      mix = crc[0] ^ d[0];
      crc = {1'b0, crc[15:1]};
      if (mix) begin
        crc = crc ^ CRC_POLY;
      end
      d = {1'b0, d[7:1]};
    end
    return crc;
  endfunction

endpackage

[hdl/cpf_ifs.sv]
// Channel interfaces for the CRC-16 packet framer: body-byte input channel and
// line-byte output channel with valid/ready handshakes. Depends on cpf_pkg.
interface cpf_in_if;
  logic            valid;
  logic            ready;
  cpf_pkg::byte_t  body_byte;
  logic            last_of_body;

  modport source (output valid, output body_byte, output last_of_body, input ready);
  modport sink   (input valid, input body_byte, input last_of_body, output ready);
endinterface

interface cpf_out_if;
  logic            valid;
  logic            ready;
  cpf_pkg::byte_t  line_byte;
  logic            frame_end;

  modport source (output valid, output line_byte, output frame_end, input ready);
  modport sink   (input valid, input line_byte, input frame_end, output ready);
endinterface

[hdl/crc16_packet_framer.sv]
// Top level of the CRC-16 packet framer: frames body bytes with start byte,
// CRC-16 trailer and end byte. Depends on cpf_pkg and the channel interfaces.
//
// Each accepted body byte yields one line beat, two when it opens a frame
// (0xC0 then the byte) and four when it closes one (the byte, CRC low, CRC
// high, 0xC1 with frame_end set). The CRC is updated in the accept cycle and
// all beats of an item are loaded into a four-entry output shift register, so
// the line side emits one beat per cycle while out_chan.ready is high, and the
// next body byte is taken in the same cycle as the last beat of the previous
// item leaves. Mid-frame bytes therefore flow at one per cycle while ready.
module crc16_packet_framer (
  input  logic       clk,
  input  logic       rst_n,
  cpf_in_if.sink     in_chan,
  cpf_out_if.source  out_chan
);
  import cpf_pkg::*;

  byte_t      slot_r [4];
  byte_t      slot_nxt [4];
  logic       valid_r, valid_nxt;
  logic       end_r, end_nxt;
  logic [1:0] rem_r, rem_nxt;
  crc_t       crc_r, crc_nxt;
  logic       in_frame_r, in_frame_nxt;

  logic       last_beat;
  logic       pop;
  logic       accept;
  crc_t       crc_fold_val;

  assign last_beat = (rem_r == 2'd0);
  assign pop       = valid_r && out_chan.ready;
  assign in_chan.ready = !valid_r || (last_beat && out_chan.ready);
  assign accept    = in_chan.valid && in_chan.ready;

  assign crc_fold_val = crc_fold(in_frame_r ? crc_r : '0, in_chan.body_byte);

  assign out_chan.valid     = valid_r;
  assign out_chan.line_byte = slot_r[0];
  assign out_chan.frame_end = valid_r && end_r && last_beat;

  always_comb begin
    slot_nxt     = slot_r;
    valid_nxt    = valid_r;
    end_nxt      = end_r;
    rem_nxt      = rem_r;
    crc_nxt      = crc_r;
    in_frame_nxt = in_frame_r;
    if (accept) begin
      valid_nxt = 1'b1;
      if (!in_frame_r) begin
        slot_nxt[0]  = START_BYTE;
        slot_nxt[1]  = in_chan.body_byte;
        rem_nxt      = 2'd1;
        end_nxt      = 1'b0;
        crc_nxt      = crc_fold_val;
        in_frame_nxt = 1'b1;
      end else if (in_chan.last_of_body) begin
        slot_nxt[0]  = in_chan.body_byte;
        slot_nxt[1]  = crc_fold_val[7:0];
        slot_nxt[2]  = crc_fold_val[15:8];
        slot_nxt[3]  = END_BYTE;
        rem_nxt      = 2'd3;
        end_nxt      = 1'b1;
        crc_nxt      = '0;
        in_frame_nxt = 1'b0;
      end else begin
        slot_nxt[0] = in_chan.body_byte;
        rem_nxt     = 2'd0;
        end_nxt     = 1'b0;
        crc_nxt     = crc_fold_val;
      end
    end else if (pop) begin
      if (last_beat) begin
        valid_nxt = 1'b0;
      end else begin
        slot_nxt[0] = slot_r[1];
        slot_nxt[1] = slot_r[2];
        slot_nxt[2] = slot_r[3];
        rem_nxt     = rem_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    end_r  <= end_nxt;
    if (!rst_n) begin
      valid_r    <= 1'b0;
      rem_r      <= 2'd0;
      crc_r      <= '0;
      in_frame_r <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      rem_r      <= rem_nxt;
      crc_r      <= crc_nxt;
      in_frame_r <= in_frame_nxt;
    end
  end

`ifndef SYNTHESIS
  a_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.frame_end |-> out_chan.line_byte == END_BYTE)
    else $error("frame_end on a beat that is not the end byte");

  a_open_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_frame_r) |=> (valid_r && slot_r[0] == START_BYTE && in_frame_r))
    else $error("frame opened without a start byte");

  a_close_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_frame_r && in_chan.last_of_body) |=>
      (!in_frame_r && crc_r == '0 && rem_r == 2'd3))
    else $error("frame close did not clear state or load trailer");

  a_rem_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r != 2'd0) |-> valid_r)
    else $error("pending beats without valid output");
`endif

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// Testbench for crc16_packet_framer: drives body-byte frames and checks the line beats
// against a local framing and CRC-16 predictor. Depends on cpf_pkg, cpf_ifs, the block.
module testbench;
  import cpf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    byte_t line_byte;
    logic  frame_end;
  } line_beat_t;

  logic clk;
  logic rst_n;

  cpf_in_if  in_ch ();
  cpf_out_if out_ch ();

  crc16_packet_framer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  line_beat_t line_q[$];
  crc_t       crc_acc;
  logic       frame_open;
  int         error_cnt;
  int         items_sent;
  int         frames_closed;
  int         beats_checked;
  int         cycle_cnt;
  int         hold_left;
  bit         idle_en;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt, line_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_cnt++;
  endtask

  function automatic crc_t crc16_update(input crc_t crc, input byte_t data);
    crc_t r;
    r = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  task automatic push_line(input byte_t b, input logic fe);
    line_beat_t lb;
    lb.line_byte = b;
    lb.frame_end = fe;
    line_q.push_back(lb);
  endtask

  // Work out the line beats caused by one accepted body byte.
  task automatic predict_line(input byte_t b, input logic last);
    logic closing;
    closing = last;
    if (!frame_open) begin
      push_line(START_BYTE, 1'b0);
      frame_open = 1'b1;
      crc_acc = '0;
      closing = 1'b0;
    end
    push_line(b, 1'b0);
    crc_acc = crc16_update(crc_acc, b);
    if (closing) begin
      push_line(crc_acc[7:0], 1'b0);
      push_line(crc_acc[15:8], 1'b0);
      push_line(END_BYTE, 1'b1);
      crc_acc = '0;
      frame_open = 1'b0;
      frames_closed++;
    end
  endtask

  task automatic send_beat(input byte_t b, input logic last);
    while (idle_en && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.body_byte    <= b;
    in_ch.last_of_body <= last;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    predict_line(b, last);
    items_sent++;
  endtask

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) begin
      send_beat(8'($urandom), (i == len - 1));
    end
  endtask

  // Line side: check each accepted beat, then pick ready for the next cycle.
  initial begin
    line_beat_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        beats_checked++;
        if (line_q.size() == 0) begin
          flag_error($sformatf("unexpected beat line_byte=%h frame_end=%b",
                               out_ch.line_byte, out_ch.frame_end));
        end else begin
          want = line_q.pop_front();
          if (out_ch.line_byte !== want.line_byte)
            flag_error($sformatf("line_byte got %h want %h", out_ch.line_byte, want.line_byte));
          if (out_ch.frame_end !== want.frame_end)
            flag_error($sformatf("frame_end got %b want %b (line_byte %h)",
                                 out_ch.frame_end, want.frame_end, want.line_byte));
        end
      end
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(idle_en && $urandom_range(99) < 12);
      end
    end
  end

  task automatic test_reset();
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.body_byte    <= '0;
    in_ch.last_of_body <= 1'b0;
    frame_open = 1'b0;
    crc_acc    = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  task automatic test_field_extremes();
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h01, 1'b1);
  endtask

  task automatic test_framing_codes_in_body();
    send_beat(START_BYTE, 1'b0);
    send_beat(END_BYTE, 1'b0);
    send_beat(8'h55, 1'b0);
    send_beat(8'hAA, 1'b1);
  endtask

  // Last flag on the byte that opens a frame is dropped; the frame stays open.
  task automatic test_last_on_opening_byte();
    send_beat(8'hA5, 1'b1);
    send_beat(8'h5A, 1'b1);
    send_beat(8'h3C, 1'b1);
    send_beat(8'h0F, 1'b0);
    send_beat(8'hF0, 1'b1);
  endtask

  task automatic test_random_frames(input int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(19) == 0)
          send_frame($urandom_range(20, 40));
        else
          send_frame($urandom_range(2, 10));
      end else begin
        send_beat(8'($urandom), 1'($urandom_range(1)));
      end
    end
  endtask

  // Hold off the line side long enough that the block fills and stalls its input.
  task automatic test_line_backpressure();
    hold_left = 200;
    send_frame(12);
    send_frame(3);
  endtask

  task automatic test_full_rate_stream();
    idle_en = 1'b0;
    send_frame(16);
    send_frame(2);
    send_frame(2);
    idle_en = 1'b1;
  endtask

  initial begin
    error_cnt     = 0;
    items_sent    = 0;
    frames_closed = 0;
    beats_checked = 0;
    cycle_cnt     = 0;
    hold_left     = 0;
    idle_en       = 1'b1;

    test_reset();
    test_field_extremes();
    test_framing_codes_in_body();
    test_last_on_opening_byte();
    test_line_backpressure();
    test_full_rate_stream();
    test_random_frames(118);
    send_frame(2);
    in_ch.valid <= 1'b0;

    while (line_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d body bytes, closed %0d frames, checked %0d line beats",
             items_sent, frames_closed, beats_checked);
    $display("covered byte extremes, framing codes in body, dropped opening last flag, stalls");
    if (error_cnt == 0 && line_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d errors, %0d beats never seen", error_cnt, line_q.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[crc16_packet_framer.f]
hdl/cpf_pkg.sv
hdl/cpf_ifs.sv
hdl/crc16_packet_framer.sv
test/testbench.sv
